// ===== rtl/hcbd_pkg.sv =====
// ----------------------------------------------------------------------------
// hcbd_pkg
// Shared types and constants for the HTTP/1.1 chunked body decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package hcbd_pkg;

  // Default width of the chunk size accumulator and the data byte counter
  localparam int unsigned SizeBitsDef = 32;

  // Decoder phase
  typedef enum logic [2:0] {
    PhSize     = 3'd0,
    PhSkipCr   = 3'd1,
    PhData     = 3'd2,
    PhSkipTail = 3'd3,
    PhDone     = 3'd4,
    PhBad      = 3'd5
  } phase_e;

  // Status codes shown with every result
  typedef enum logic [1:0] {
    StInProgress = 2'd0,
    StComplete   = 2'd1,
    StBadRequest = 2'd2
  } status_e;

  // Characters of the size line
  localparam logic [7:0] ChZero  = 8'h30;  // '0'
  localparam logic [7:0] ChNine  = 8'h39;  // '9'
  localparam logic [7:0] ChLowA  = 8'h61;  // 'a'
  localparam logic [7:0] ChLowF  = 8'h66;  // 'f'
  localparam logic [7:0] ChCr    = 8'h0D;  // carriage return

  // Bytes skipped after the size line CR and after the chunk data
  localparam logic [1:0] SkipAfterCr   = 2'd1;
  localparam logic [1:0] SkipAfterData = 2'd2;

  // One result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    status_e    status;
  } result_t;

  // Lowercase hex decode: bit 4 flags a digit, bits 3:0 carry its value
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= ChZero && c <= ChNine) begin
      r = {1'b1, 4'(c - ChZero)};
    end else if (c >= ChLowA && c <= ChLowF) begin
      r = {1'b1, 4'(c - ChLowA + 8'd10)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/hcbd_step.sv =====
// ----------------------------------------------------------------------------
// hcbd_step
// Decoder state and the combinational update for one accepted body byte.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbd_step #(
  parameter int unsigned SizeBits = hcbd_pkg::SizeBitsDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic [7:0]        byte_i,
  output hcbd_pkg::result_t      result_o
);

  localparam int unsigned MaxDigits = SizeBits / 4;
  localparam int unsigned CntW      = $clog2(MaxDigits + 1);

  hcbd_pkg::phase_e      phase_q, phase_d;
  logic [SizeBits-1:0]   size_q, size_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [SizeBits-1:0]   remaining_q, remaining_d;
  logic [1:0]            skip_q, skip_d;
  logic [4:0]            hex;

  assign hex = hcbd_pkg::hex_value(byte_i);

  // Next state and payload for the current byte
  always_comb begin
    phase_d     = phase_q;
    size_d      = size_q;
    cnt_d       = cnt_q;
    remaining_d = remaining_q;
    skip_d      = skip_q;
    result_o.out_byte  = '0;
    result_o.out_valid = 1'b0;
    unique case (phase_q)
      hcbd_pkg::PhSize: begin
        if (hex[4]) begin
          // too many digits is a bad request
          if (cnt_q >= CntW'(MaxDigits)) begin
            phase_d = hcbd_pkg::PhBad;
          end else begin
            size_d = {size_q[SizeBits-5:0], hex[3:0]};
            cnt_d  = cnt_q + 1'b1;
          end
        end else if (byte_i == hcbd_pkg::ChCr) begin
          // empty or zero size line ends the message
          if (size_q == '0) begin
            phase_d = hcbd_pkg::PhDone;
          end else begin
            remaining_d = size_q;
            skip_d      = hcbd_pkg::SkipAfterCr;
            phase_d     = hcbd_pkg::PhSkipCr;
          end
          size_d = '0;
          cnt_d  = '0;
        end else begin
          phase_d = hcbd_pkg::PhBad;
        end
      end
      hcbd_pkg::PhSkipCr: begin
        skip_d  = '0;
        phase_d = hcbd_pkg::PhData;
      end
      hcbd_pkg::PhData: begin
        result_o.out_byte  = byte_i;
        result_o.out_valid = 1'b1;
        remaining_d = remaining_q - 1'b1;
        if (remaining_d == '0) begin
          skip_d  = hcbd_pkg::SkipAfterData;
          phase_d = hcbd_pkg::PhSkipTail;
        end
      end
      hcbd_pkg::PhSkipTail: begin
        skip_d = skip_q - 2'd1;
        if (skip_d == '0) begin
          phase_d = hcbd_pkg::PhSize;
        end
      end
      hcbd_pkg::PhDone: begin
        phase_d = hcbd_pkg::PhDone;
      end
      default: begin
        // unused codes and the error phase stay in error
        phase_d = hcbd_pkg::PhBad;
      end
    endcase

    // Status follows the updated phase
    unique case (phase_d)
      hcbd_pkg::PhDone: result_o.status = hcbd_pkg::StComplete;
      hcbd_pkg::PhBad:  result_o.status = hcbd_pkg::StBadRequest;
      default:          result_o.status = hcbd_pkg::StInProgress;
    endcase
  end

  // State registers, updated once per accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= hcbd_pkg::PhSize;
      size_q      <= '0;
      cnt_q       <= '0;
      remaining_q <= '0;
      skip_q      <= '0;
    end else if (accept_i) begin
      phase_q     <= phase_d;
      size_q      <= size_d;
      cnt_q       <= cnt_d;
      remaining_q <= remaining_d;
      skip_q      <= skip_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hcbd_out_reg.sv =====
// ----------------------------------------------------------------------------
// hcbd_out_reg
// Result register with valid/ready handshake toward the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbd_out_reg (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire hcbd_pkg::result_t  result_i,
  output      logic               res_valid_o,
  input  wire logic               res_ready_i,
  output hcbd_pkg::result_t       result_o,
  output      logic               accept_o
);

  logic              valid_q;
  hcbd_pkg::result_t data_q;

  // A new byte is taken when the register is empty or drains this cycle
  assign in_ready_o = !valid_q || res_ready_i;
  assign accept_o   = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept_o) begin
      valid_q <= 1'b1;
    end else if (res_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    if (accept_o) begin
      data_q <= result_i;
    end
  end

  assign res_valid_o = valid_q;
  assign result_o    = data_q;

endmodule

`default_nettype wire

// ===== rtl/http_chunked_body_decoder_top.sv =====
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_top
// HTTP/1.1 chunked body decoder, one byte per cycle while results are taken.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries raw body bytes. Each
//   accepted byte yields exactly one result on the output channel
//   (res_valid_o/res_ready_i): out_byte_o/out_valid_o mark payload bytes,
//   status_o reads 0 in progress, 1 message complete, 2 bad request.
//   The result of a byte accepted at an edge is shown from that edge onward.
//   Throughput is one byte per cycle while the receiver takes results; the
//   state update is a single pass of hex decode, shift-in and a SIZE_BITS-wide
//   decrement between the state registers and the result register.
//   Reset returns the decoder to the start of a size line and empties the
//   result register. When the receiver stalls, the result register holds
//   and in_ready_o drops; it rises again in the cycle the result is taken.
//   Complete and bad request are sticky until reset.
// ----------------------------------------------------------------------------
`default_nettype none

module http_chunked_body_decoder_top #(
  parameter int unsigned SIZE_BITS = hcbd_pkg::SizeBitsDef
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output      logic       in_ready_o,
  input  wire logic [7:0] in_byte_i,
  output      logic       res_valid_o,
  input  wire logic       res_ready_i,
  output      logic [7:0] out_byte_o,
  output      logic       out_valid_o,
  output      logic [1:0] status_o
);

  hcbd_pkg::result_t step_res;
  hcbd_pkg::result_t out_res;
  logic              accept;

  // State update
  hcbd_step #(
    .SizeBits (SIZE_BITS)
  ) u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (in_byte_i),
    .result_o (step_res)
  );

  // Result register
  hcbd_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .result_i    (step_res),
    .res_valid_o (res_valid_o),
    .res_ready_i (res_ready_i),
    .result_o    (out_res),
    .accept_o    (accept)
  );

  assign out_byte_o  = out_res.out_byte;
  assign out_valid_o = out_res.out_valid;
  assign status_o    = 2'(out_res.status);

endmodule

`default_nettype wire

// ===== rtl/hcbd_checker.sv =====
// ----------------------------------------------------------------------------
// hcbd_checker
// Port-level checks for the chunked body decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbd_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_ready_o,
  input wire logic       res_valid_o,
  input wire logic       res_ready_i,
  input wire logic [7:0] out_byte_o,
  input wire logic       out_valid_o,
  input wire logic [1:0] status_o
);

  logic done_seen_q;

  // Remember a completed message seen on a transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_seen_q <= 1'b0;
    end else if (res_valid_o && res_ready_i &&
                 status_o == 2'(hcbd_pkg::StComplete)) begin
      done_seen_q <= 1'b1;
    end
  end

  // Stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_ready_i |=> res_valid_o && $stable(out_byte_o) &&
    $stable(out_valid_o) && $stable(status_o))
    else $error("stalled result changed");

  // Empty result register always takes a byte
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  // Non-payload results carry a zero byte
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !out_valid_o |-> out_byte_o == 8'h00)
    else $error("non-payload result with nonzero byte");

  // Payload only while the message is in progress
  a_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && out_valid_o |-> status_o == 2'(hcbd_pkg::StInProgress))
    else $error("payload after end or error");

  // Completion is sticky
  a_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && done_seen_q |-> status_o == 2'(hcbd_pkg::StComplete))
    else $error("status left complete");

endmodule

bind http_chunked_body_decoder_top hcbd_checker u_hcbd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .res_valid_o (res_valid_o),
  .res_ready_i (res_ready_i),
  .out_byte_o  (out_byte_o),
  .out_valid_o (out_valid_o),
  .status_o    (status_o)
);

`default_nettype wire
